/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is active
`define DVRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is active
`define DVRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/dvru_pkg.sv */
// types and constants of the distance-vector route update block
package dvru_pkg;

  localparam int unsigned OwnIdBits = 8;
  localparam int unsigned ApbDataBits = 32;
  localparam int unsigned ApbAddrBits = 3;

  // register indexes, taken from paddr[2]
  typedef enum logic {
    REG_OWN_ROUTER_ID = 1'b0
  } reg_idx_e;

  typedef enum logic [2:0] {
    STATUS_IGNORED   = 3'd0,
    STATUS_UNCHANGED = 3'd1,
    STATUS_SAME_HOP  = 3'd2,
    STATUS_BETTER    = 3'd3,
    STATUS_NEW       = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_IDLE   = 3'b010,
    S_LOOKUP = 3'b100
  } state_e;

  typedef struct packed {
    logic    wr_en;
    status_e status;
    logic    advertise;
  } upd_ctrl_t;

endpackage

/* hdl/dvru_ram.sv */
// generic simple dual-port ram with registered read
module dvru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/dvru_update.sv */
// route entry update decision with saturating cost sum
module dvru_update #(
  parameter int unsigned NODE_BITS = 8,
  parameter int unsigned COST_BITS = 16
) (
  input  logic [NODE_BITS-1:0] own_node_i,
  input  logic [NODE_BITS-1:0] dest_i,
  input  logic [NODE_BITS-1:0] nbr_i,
  input  logic [COST_BITS-1:0] adv_cost_i,
  input  logic [COST_BITS-1:0] link_cost_i,
  input  logic                 ent_valid_i,
  input  logic [NODE_BITS-1:0] ent_hop_i,
  input  logic [COST_BITS-1:0] ent_cost_i,
  output dvru_pkg::upd_ctrl_t  ctrl_o,
  output logic [NODE_BITS-1:0] new_hop_o,
  output logic [COST_BITS-1:0] upd_cost_o
);

  import dvru_pkg::*;

  localparam logic [COST_BITS-1:0] CostInf = '1;

  logic [COST_BITS:0]   sum_raw;
  logic [COST_BITS-1:0] sum_sat;
  logic [COST_BITS-1:0] same_cost;
  logic                 adv_inf;

  assign sum_raw   = {1'b0, adv_cost_i} + {1'b0, link_cost_i};
  assign sum_sat   = sum_raw[COST_BITS] ? CostInf : sum_raw[COST_BITS-1:0];
  assign adv_inf   = (adv_cost_i == CostInf);
  assign same_cost = adv_inf ? CostInf : sum_sat;

  always_comb begin
    ctrl_o.wr_en     = 1'b0;
    ctrl_o.status    = STATUS_UNCHANGED;
    ctrl_o.advertise = 1'b0;
    new_hop_o        = ent_hop_i;
    upd_cost_o       = ent_cost_i;
    if (dest_i == own_node_i) begin
      ctrl_o.status = STATUS_IGNORED;
      new_hop_o     = '0;
      upd_cost_o    = '0;
    end else if (!ent_valid_i) begin
      ctrl_o.wr_en     = 1'b1;
      ctrl_o.status    = STATUS_NEW;
      ctrl_o.advertise = 1'b1;
      new_hop_o        = nbr_i;
      upd_cost_o       = sum_sat;
    end else if (ent_hop_i == nbr_i) begin
      ctrl_o.wr_en     = 1'b1;
      ctrl_o.status    = STATUS_SAME_HOP;
      ctrl_o.advertise = (same_cost != ent_cost_i);
      upd_cost_o       = same_cost;
    end else if (!adv_inf && (sum_sat < ent_cost_i)) begin
      ctrl_o.wr_en     = 1'b1;
      ctrl_o.status    = STATUS_BETTER;
      ctrl_o.advertise = 1'b1;
      new_hop_o        = nbr_i;
      upd_cost_o       = sum_sat;
    end
  end

endmodule

/* hdl/distance_vector_route_update.sv */
// top level: routing table update
//
//  channel  direction  handshake                   payload
//  in       sink       in_valid_i / in_stall_o     adv_dest, nbr_id, adv_cost, link_cost
//  out      source     out_valid_o / out_stall_i   status, route_dest/hop/cost, advertise
//  cfg      apb slave  psel/penable/pwrite/pready  own_router_id at address 0
//
// per request: table read, then update, write-back and result register
// the table ram's registered read sets this order
// after reset a clearing pass over all 2**NODE_BITS entries empties the table, in_stall_o held high
// a stalled result holds the update cycle; a new request is taken while a result waits
module distance_vector_route_update #(
  parameter int unsigned NODE_BITS = 8,
  parameter int unsigned COST_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dvru_pkg::ApbAddrBits-1:0]     paddr,
  input  logic [dvru_pkg::ApbDataBits-1:0]     pwdata,
  output logic [dvru_pkg::ApbDataBits-1:0]     prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [NODE_BITS-1:0]                 adv_dest_i,
  input  logic [NODE_BITS-1:0]                 nbr_id_i,
  input  logic [COST_BITS-1:0]                 adv_cost_i,
  input  logic [COST_BITS-1:0]                 link_cost_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           status_o,
  output logic [NODE_BITS-1:0]                 route_dest_o,
  output logic [NODE_BITS-1:0]                 route_hop_o,
  output logic [COST_BITS-1:0]                 route_cost_o,
  output logic                                 advertise_o
);

  import dvru_pkg::*;

  localparam int unsigned Depth = 1 << NODE_BITS;
  localparam int unsigned EntW  = 1 + NODE_BITS + COST_BITS;

  state_e state_q, state_d;
  logic [NODE_BITS-1:0] clr_q, clr_d;
  logic [OwnIdBits-1:0] own_q;

  logic [NODE_BITS-1:0] dest_q, nbr_q;
  logic [COST_BITS-1:0] adv_q, link_q;

  logic                 out_valid_q;
  logic [2:0]           status_q;
  logic [NODE_BITS-1:0] odest_q, ohop_q;
  logic [COST_BITS-1:0] ocost_q;
  logic                 oadv_q;

  logic                 in_acc, out_free, load_out, cfg_wr;
  logic                 ram_we;
  logic [NODE_BITS-1:0] ram_waddr;
  logic [EntW-1:0]      ram_wdata, ram_rdata;
  logic [NODE_BITS-1:0] own_node;
  upd_ctrl_t            upd_ctrl;
  logic [NODE_BITS-1:0] new_hop;
  logic [COST_BITS-1:0] upd_cost;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (reg_idx_e'(paddr[2]) == REG_OWN_ROUTER_ID)
                  ? ApbDataBits'(own_q) : '0;
  assign own_node = NODE_BITS'(own_q);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == S_LOOKUP) && out_free;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      own_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
      if (cfg_wr && (reg_idx_e'(paddr[2]) == REG_OWN_ROUTER_ID)) begin
        own_q <= pwdata[OwnIdBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dest_q <= adv_dest_i;
      nbr_q  <= nbr_id_i;
      adv_q  <= adv_cost_i;
      link_q <= link_cost_i;
    end
    if (load_out) begin
      status_q <= upd_ctrl.status;
      odest_q  <= dest_q;
      ohop_q   <= new_hop;
      ocost_q  <= upd_cost;
      oadv_q   <= upd_ctrl.advertise;
    end
  end

  dvru_update #(
    .NODE_BITS(NODE_BITS),
    .COST_BITS(COST_BITS)
  ) u_update (
    .own_node_i (own_node),
    .dest_i     (dest_q),
    .nbr_i      (nbr_q),
    .adv_cost_i (adv_q),
    .link_cost_i(link_q),
    .ent_valid_i(ram_rdata[EntW-1]),
    .ent_hop_i  (ram_rdata[EntW-2 -: NODE_BITS]),
    .ent_cost_i (ram_rdata[COST_BITS-1:0]),
    .ctrl_o     (upd_ctrl),
    .new_hop_o  (new_hop),
    .upd_cost_o (upd_cost)
  );

  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = load_out && upd_ctrl.wr_en;
      ram_waddr = dest_q;
      ram_wdata = {1'b1, new_hop, upd_cost};
    end
  end

  dvru_ram #(
    .WIDTH(EntW),
    .DEPTH(Depth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_acc),
    .raddr_i(adv_dest_i),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign route_dest_o = odest_q;
  assign route_hop_o  = ohop_q;
  assign route_cost_o = ocost_q;
  assign advertise_o  = oadv_q;

endmodule

/* hdl/dvru_checker.sv */
// port-level checks for the route update block, bound to the top level
`include "assert_macros.svh"

module dvru_checker #(
  parameter int unsigned NODE_BITS = 8,
  parameter int unsigned COST_BITS = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [2:0]           status_o,
  input logic [NODE_BITS-1:0] route_hop_o,
  input logic [COST_BITS-1:0] route_cost_o,
  input logic                 advertise_o
);

  import dvru_pkg::*;

  // one request at a time: stall follows every accepted request
  `DVRU_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  `DVRU_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `DVRU_ASSERT_NOW(a_ignored_zero, clk_i, rst_ni,
    out_valid_o && (status_o == STATUS_IGNORED),
    !advertise_o && (route_hop_o == '0) && (route_cost_o == '0))

  `DVRU_ASSERT_NOW(a_advertise_status, clk_i, rst_ni,
    out_valid_o && ((status_o == STATUS_NEW) || (status_o == STATUS_BETTER)),
    advertise_o)

  `DVRU_ASSERT_NOW(a_unchanged_quiet, clk_i, rst_ni,
    out_valid_o && (status_o == STATUS_UNCHANGED), !advertise_o)

endmodule

bind distance_vector_route_update dvru_checker #(
  .NODE_BITS(NODE_BITS),
  .COST_BITS(COST_BITS)
) u_dvru_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .route_hop_o (route_hop_o),
  .route_cost_o(route_cost_o),
  .advertise_o (advertise_o)
);

/* sim/tb.sv */
// testbench for the distance-vector route update block: directed and random advertisements
`timescale 1ns / 1ps

module tb;
  import dvru_pkg::*;

  localparam int unsigned NODE_BITS = 8;
  localparam int unsigned COST_BITS = 16;
  localparam int unsigned NODES = 1 << NODE_BITS;
  localparam logic [COST_BITS-1:0] COST_INF = '1;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [NODE_BITS-1:0] dest;
    logic [NODE_BITS-1:0] nbr;
    logic [COST_BITS-1:0] adv;
    logic [COST_BITS-1:0] link;
  } route_adv_t;

  typedef struct packed {
    status_e              status;
    logic [NODE_BITS-1:0] dest;
    logic [NODE_BITS-1:0] hop;
    logic [COST_BITS-1:0] cost;
    logic                 adv;
  } route_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ApbAddrBits-1:0] paddr = '0;
  logic [ApbDataBits-1:0] pwdata = '0;
  logic [ApbDataBits-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [NODE_BITS-1:0] adv_dest_i = '0;
  logic [NODE_BITS-1:0] nbr_id_i = '0;
  logic [COST_BITS-1:0] adv_cost_i = '0;
  logic [COST_BITS-1:0] link_cost_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [NODE_BITS-1:0] route_dest_o;
  logic [NODE_BITS-1:0] route_hop_o;
  logic [COST_BITS-1:0] route_cost_o;
  logic advertise_o;

  distance_vector_route_update #(
    .NODE_BITS(NODE_BITS),
    .COST_BITS(COST_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .adv_dest_i  (adv_dest_i),
    .nbr_id_i    (nbr_id_i),
    .adv_cost_i  (adv_cost_i),
    .link_cost_i (link_cost_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .route_dest_o(route_dest_o),
    .route_hop_o (route_hop_o),
    .route_cost_o(route_cost_o),
    .advertise_o (advertise_o)
  );

  // shadow routing table and register
  bit                   route_ok [NODES];
  logic [NODE_BITS-1:0] hop_tbl  [NODES];
  logic [COST_BITS-1:0] cost_tbl [NODES];
  logic [NODE_BITS-1:0] own_id = '0;

  route_adv_t adv_q[$];
  route_res_t route_exp_q[$];
  route_res_t want;
  int err_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic route_res_t update_route(input logic [NODE_BITS-1:0] dest,
                                              input logic [NODE_BITS-1:0] nbr,
                                              input logic [COST_BITS-1:0] adv,
                                              input logic [COST_BITS-1:0] link);
    route_res_t r;
    logic [COST_BITS:0] raw;
    logic [COST_BITS-1:0] sum;
    logic [COST_BITS-1:0] old;
    raw = {1'b0, adv} + {1'b0, link};
    sum = (raw > {1'b0, COST_INF}) ? COST_INF : raw[COST_BITS-1:0];
    r.status = STATUS_IGNORED;
    r.dest = dest;
    r.hop = '0;
    r.cost = '0;
    r.adv = 1'b0;
    if (dest == own_id) begin
      r.status = STATUS_IGNORED;
    end else if (route_ok[dest]) begin
      if (hop_tbl[dest] == nbr) begin
        old = cost_tbl[dest];
        cost_tbl[dest] = (adv == COST_INF) ? COST_INF : sum;
        r.adv = (cost_tbl[dest] != old);
        r.status = STATUS_SAME_HOP;
      end else if (adv != COST_INF && sum < cost_tbl[dest]) begin
        cost_tbl[dest] = sum;
        hop_tbl[dest] = nbr;
        r.adv = 1'b1;
        r.status = STATUS_BETTER;
      end else begin
        r.status = STATUS_UNCHANGED;
      end
      r.hop = hop_tbl[dest];
      r.cost = cost_tbl[dest];
    end else begin
      route_ok[dest] = 1'b1;
      hop_tbl[dest] = nbr;
      cost_tbl[dest] = sum;
      r.hop = nbr;
      r.cost = sum;
      r.adv = 1'b1;
      r.status = STATUS_NEW;
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        route_exp_q.push_back(update_route(adv_dest_i, nbr_id_i, adv_cost_i, link_cost_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (adv_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          adv_dest_i  <= adv_q[0].dest;
          nbr_id_i    <= adv_q[0].nbr;
          adv_cost_i  <= adv_q[0].adv;
          link_cost_i <= adv_q[0].link;
          in_valid_i  <= 1'b1;
          adv_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side stall, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (route_exp_q.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want = route_exp_q.pop_front();
        if (status_o !== want.status)
          flag_mismatch($sformatf("dest %0d status %0d want %0d",
                                  want.dest, status_o, want.status));
        if (route_dest_o !== want.dest)
          flag_mismatch($sformatf("route_dest %0d want %0d", route_dest_o, want.dest));
        if (route_hop_o !== want.hop)
          flag_mismatch($sformatf("dest %0d hop %0d want %0d",
                                  want.dest, route_hop_o, want.hop));
        if (route_cost_o !== want.cost)
          flag_mismatch($sformatf("dest %0d cost %0d want %0d",
                                  want.dest, route_cost_o, want.cost));
        if (advertise_o !== want.adv)
          flag_mismatch($sformatf("dest %0d advertise %0b want %0b",
                                  want.dest, advertise_o, want.adv));
      end
    end
  end

  task automatic write_own_id(input logic [NODE_BITS-1:0] id);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_OWN_ROUTER_ID, 2'b00};
    pwdata  <= ApbDataBits'(id);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    own_id = id;
  endtask

  task automatic push_adv(input logic [NODE_BITS-1:0] dest, input logic [NODE_BITS-1:0] nbr,
                          input logic [COST_BITS-1:0] adv, input logic [COST_BITS-1:0] link);
    adv_q.push_back('{dest, nbr, adv, link});
  endtask

  function automatic route_adv_t random_adv(input logic [NODE_BITS-1:0] base);
    route_adv_t a;
    if ($urandom_range(9) == 0) begin
      a.dest = NODE_BITS'($urandom_range(NODES - 1));
      a.nbr  = NODE_BITS'($urandom_range(NODES - 1));
    end else begin
      a.dest = base + NODE_BITS'($urandom_range(15));
      a.nbr  = NODE_BITS'($urandom_range(5));
    end
    case ($urandom_range(9))
      0:       a.adv = COST_INF;
      1:       a.adv = COST_BITS'($urandom_range(65535));
      2:       a.adv = COST_BITS'($urandom_range(65535, 60000));
      default: a.adv = COST_BITS'($urandom_range(300));
    endcase
    case ($urandom_range(19))
      0:       a.link = COST_INF;
      1, 2:    a.link = COST_BITS'($urandom_range(65534));
      default: a.link = COST_BITS'($urandom_range(100));
    endcase
    return a;
  endfunction

  // checked at the falling edge so that the driver's updates have settled
  task automatic wait_drained();
    while (adv_q.size() != 0 || in_valid_i || route_exp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [NODE_BITS-1:0] base;
    logic [NODE_BITS-1:0] id;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    write_own_id('0);
    write_own_id(8'd7);
    push_adv(8'd7,   8'd1,   16'd5,     16'd5);
    push_adv(8'd255, 8'd255, COST_INF,  16'd65534);
    push_adv(8'd0,   8'd0,   16'd0,     16'd0);
    push_adv(8'd1,   8'd2,   16'd10,    16'd5);
    push_adv(8'd1,   8'd3,   16'd5,     16'd5);
    push_adv(8'd1,   8'd2,   16'd20,    16'd1);
    push_adv(8'd1,   8'd3,   16'd5,     16'd5);
    push_adv(8'd1,   8'd3,   16'd7,     16'd5);
    push_adv(8'd1,   8'd4,   COST_INF,  16'd0);
    push_adv(8'd1,   8'd3,   COST_INF,  16'd3);
    push_adv(8'd1,   8'd4,   16'd65534, 16'd0);
    push_adv(8'd1,   8'd5,   16'd65000, 16'd1000);
    push_adv(8'd1,   8'd4,   16'd40000, 16'd40000);
    push_adv(8'd2,   8'd9,   16'd0,     COST_INF);
    push_adv(8'd128, 8'd170, 16'd43690, 16'd21845);
    push_adv(8'd85,  8'd85,  16'd32768, 16'd32767);
    push_adv(8'd0,   8'd0,   COST_INF,  16'd65534);
    push_adv(8'd0,   8'd1,   16'd0,     16'd0);
    push_adv(8'd255, 8'd0,   16'd100,   16'd100);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      base = (p == 1) ? 8'd240 : NODE_BITS'($urandom_range(NODES - 1));
      if (p == 0) id = '0;
      else if (p == 1) id = '1;
      else if (p % 2 == 1) id = base + NODE_BITS'($urandom_range(15));
      else id = NODE_BITS'($urandom_range(NODES - 1));
      write_own_id(id);
      case (p % 4)
        0: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct <= 80;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 80;
        end
        default: begin
          send_idle_pct <= 21;
          recv_stall_pct <= 21;
        end
      endcase
      // back-pressure burst: results held while requests keep coming
      if (p == 4) hold_req <= hold_req + 1;
      for (int n = 0; n < 130; n++) adv_q.push_back(random_adv(base));
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
